FILE: sv/mec_pkg.sv
// Shared constants and payload types for the Mandelbrot escape counter.
package mec_pkg;

  localparam int FRAC_BITS = 28;
  localparam int ZW        = 32;
  localparam int PW        = 2 * ZW;
  localparam int CNT_W     = 16;

  localparam logic [CNT_W-1:0] LIMIT_RST = CNT_W'(10000);

  typedef struct packed {
    logic signed [ZW-1:0] c_real;
    logic signed [ZW-1:0] c_imag;
  } pt_t;

  typedef struct packed {
    logic [CNT_W-1:0] iter_count;
    logic             inside_res;
  } res_t;

endpackage

FILE: sv/mandelbrot_escape_counter_core.sv
// Mandelbrot escape counter: one multiplier iterated under a small sequencer.
// Each round steps the single 32x32 multiplier through zr*zr, zi*zi, zr*zi, then update.
// A point's result is registered in the zr*zi (check) step of the round that decides it.
// The next point transfers only once the sequencer is idle again; one point at a time.
// A result not yet taken holds the next point's finishing check step until it transfers.
// Reset (rst, synchronous, active high): sequencer idle, no result, limit = 10000.
module mandelbrot_escape_counter_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pt_valid,
  output logic                        pt_ready,
  input  mec_pkg::pt_t                pt,
  output logic                        res_valid,
  input  logic                        res_ready,
  output mec_pkg::res_t               res,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mec_pkg::CNT_W-1:0]   cfg_data
);
  import mec_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MUL_RR = 5'b00010,
    ST_MUL_II = 5'b00100,
    ST_MUL_RI = 5'b01000,
    ST_UPDATE = 5'b10000
  } state_t;

  localparam logic [PW:0] SMALL_TH = (PW+1)'(1) << (2 * FRAC_BITS - 4);
  localparam logic [PW:0] BIG_TH   = (PW+1)'(1) << (2 * FRAC_BITS + 2);

  state_t                  state;
  logic [CNT_W-1:0]        iter_cap;
  logic [CNT_W-1:0]        count;
  logic                    first;
  logic signed [ZW-1:0]    zr;
  logic signed [ZW-1:0]    zi;
  logic signed [ZW-1:0]    cr;
  logic signed [ZW-1:0]    ci;
  logic signed [PW-1:0]    prod;
  logic [PW-1:0]           r2;
  logic [PW-1:0]           i2;

  logic signed [ZW-1:0]    mul_a;
  logic signed [ZW-1:0]    mul_b;
  logic signed [PW-1:0]    mul_p;
  logic [PW:0]             mag_sum;
  logic                    near;
  logic                    limit;
  logic                    esc;
  logic                    finish;
  logic                    res_load;
  logic signed [PW-1:0]    diff;
  logic signed [PW-1:0]    diff_sh;
  logic signed [PW-1:0]    xy_sh;
  logic signed [ZW-1:0]    zr_next;
  logic signed [ZW-1:0]    zi_next;

  assign pt_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign mul_a = (state == ST_MUL_II) ? zi : zr;
  assign mul_b = (state == ST_MUL_RR) ? zr : zi;
  assign mul_p = mul_a * mul_b;

  assign mag_sum = {1'b0, r2} + {1'b0, prod};
  assign near    = first && (mag_sum < SMALL_TH);
  assign limit   = (count >= iter_cap);
  assign esc     = (mag_sum > BIG_TH);
  assign finish  = near || limit || esc;

  // hold until the result register is free
  assign res_load = (state == ST_MUL_RI) && finish && (!res_valid || res_ready);

  assign diff    = $signed(r2) - $signed(i2);
  assign diff_sh = diff >>> FRAC_BITS;
  assign xy_sh   = prod >>> (FRAC_BITS - 1);
  assign zr_next = diff_sh[ZW-1:0] + cr;
  assign zi_next = xy_sh[ZW-1:0] + ci;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      iter_cap  <= LIMIT_RST;
    end else begin
      if (cfg_valid) begin
        iter_cap <= cfg_data;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pt_valid) begin
            zr    <= pt.c_real;
            zi    <= pt.c_imag;
            cr    <= pt.c_real;
            ci    <= pt.c_imag;
            count <= CNT_W'(1);
            first <= 1'b1;
            state <= ST_MUL_RR;
          end
        end
        ST_MUL_RR: begin
          prod  <= mul_p;
          state <= ST_MUL_II;
        end
        ST_MUL_II: begin
          r2    <= prod;
          prod  <= mul_p;
          state <= ST_MUL_RI;
        end
        ST_MUL_RI: begin
          if (finish) begin
            if (res_load) begin
              res.iter_count <= (near || limit) ? iter_cap : count;
              res.inside_res <= near || limit;
              state          <= ST_IDLE;
            end
          end else begin
            i2    <= prod;
            prod  <= mul_p;
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          zr    <= zr_next;
          zi    <= zi_next;
          count <= count + CNT_W'(1);
          first <= 1'b0;
          state <= ST_MUL_RR;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_start: assert property (@(posedge clk) disable iff (rst)
    pt_valid && pt_ready |=> state == ST_MUL_RR)
    else $error("point transfer did not start a round");

  a_escape_below_limit: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.inside_res |-> res.iter_count < iter_cap && res.iter_count != '0)
    else $error("escape count outside its range");

  a_update_below_limit: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPDATE |-> count < iter_cap)
    else $error("round advanced at the iteration limit");

  a_result_from_check: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == ST_MUL_RI)
    else $error("result raised outside the check step");

endmodule
